>>> rtl/core/dffea_pkg.sv
// Shared constants, types and color conversion for the flicker error scorer.
`default_nettype none
package dffea_pkg;
  localparam int PALETTE_ENTRIES_DEF = 128;
  localparam int IDX_W = 7;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_WEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_WEIGHT = 1'b1;
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;
  localparam int COMP_W = 26;

  typedef struct packed {
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] u;
    logic signed [COMP_W-1:0] v;
  } ycc_t;

  // datapath commands from the controller
  typedef struct packed {
    logic load;
    logic issue;
    logic clear;
  } dffea_cmd_t;

  function automatic ycc_t to_ycc(input logic [23:0] rgb);
    logic signed [COMP_W-1:0] r, g, b;
    ycc_t c;
    r = COMP_W'(rgb[23:16]);
    g = COMP_W'(rgb[15:8]);
    b = COMP_W'(rgb[7:0]);
    c.y = COMP_W'(19595) * r + COMP_W'(38470) * g + COMP_W'(7471) * b;
    c.u = COMP_W'(32768) * b - COMP_W'(11058) * r - COMP_W'(21710) * g;
    c.v = COMP_W'(32768) * r - COMP_W'(27439) * g - COMP_W'(5329) * b;
    return c;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/dffea_if.sv
// Valid/ready channel interfaces for pixel items and result items.
`default_nettype none
interface dffea_in_if;
  logic valid;
  logic ready;
  logic action;
  logic [6:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [6:0] index_a;
  logic [6:0] index_b;
  logic last_pixel;
  modport source(output valid, action, entry_index, red, green, blue, index_a, index_b,
                 last_pixel, input ready);
  modport sink(input valid, action, entry_index, red, green, blue, index_a, index_b,
               last_pixel, output ready);
endinterface

interface dffea_out_if;
  logic valid;
  logic ready;
  logic [63:0] visual_error;
  logic [63:0] flicker_error;
  logic [63:0] total_error;
  modport source(output valid, visual_error, flicker_error, total_error, input ready);
  modport sink(input valid, visual_error, flicker_error, total_error, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dffea_datapath.sv
// Palette memory, color conversion, error squaring and saturating sums.
`default_nettype none
module dffea_datapath #(
  parameter int PALETTE_ENTRIES = dffea_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire dffea_pkg::dffea_cmd_t cmd,
  input  wire logic [6:0] entry_index,
  input  wire logic [23:0] color,
  input  wire logic [6:0] index_a,
  input  wire logic [6:0] index_b,
  input  wire logic [15:0] luma_weight,
  input  wire logic [15:0] chroma_weight,
  input  wire logic [3:0] stage_valid,
  output logic [63:0] visual_error,
  output logic [63:0] flicker_error,
  output logic [63:0] total_error
);
  import dffea_pkg::*;
  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  // one spare bit so the entry count itself fits in the range compare
  localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic [23:0] mem [PALETTE_ENTRIES];
  logic [23:0] rd_a, rd_b, tgt1;
  logic ok_a, ok_b;

  // stage 1: memory read
  always_ff @(posedge clk) begin
    if (cmd.load && (IW'(entry_index) < IW'(PALETTE_ENTRIES)))
      mem[AW'(entry_index)] <= color;
    rd_a <= mem[AW'(index_a)];
    rd_b <= mem[AW'(index_b)];
    ok_a <= IW'(index_a) < IW'(PALETTE_ENTRIES);
    ok_b <= IW'(index_b) < IW'(PALETTE_ENTRIES);
    tgt1 <= color;
  end

  // stage 2: conversion and differences
  ycc_t ca, cb, ct;
  logic signed [27:0] ey, eu, ev;
  logic signed [26:0] fy, fu, fv;
  always_comb begin
    ca = to_ycc(ok_a ? rd_a : 24'd0);
    cb = to_ycc(ok_b ? rd_b : 24'd0);
    ct = to_ycc(tgt1);
  end
  always_ff @(posedge clk) begin
    ey <= 28'(ca.y) + 28'(cb.y) - (28'(ct.y) <<< 1);
    eu <= 28'(ca.u) + 28'(cb.u) - (28'(ct.u) <<< 1);
    ev <= 28'(ca.v) + 28'(cb.v) - (28'(ct.v) <<< 1);
    fy <= 27'(ca.y) - 27'(cb.y);
    fu <= 27'(ca.u) - 27'(cb.u);
    fv <= 27'(ca.v) - 27'(cb.v);
  end

  // stage 3: squares
  logic [27:0] my, mu, mv;
  logic [26:0] ny, nu, nv;
  logic [53:0] vis_sq;
  logic [51:0] fy_sq, fc_sq;
  always_comb begin
    my = ey[27] ? 28'(-ey) : 28'(ey);
    mu = eu[27] ? 28'(-eu) : 28'(eu);
    mv = ev[27] ? 28'(-ev) : 28'(ev);
    ny = fy[26] ? 27'(-fy) : 27'(fy);
    nu = fu[26] ? 27'(-fu) : 27'(fu);
    nv = fv[26] ? 27'(-fv) : 27'(fv);
  end
  always_ff @(posedge clk) begin
    vis_sq <= 54'(my * my) + 54'(mu * mu) + 54'(mv * mv);
    fy_sq <= 52'(ny * ny);
    fc_sq <= 52'(nu * nu) + 52'(nv * nv);
  end

  // stage 4: weighting and rounding, split into high and low partial products
  logic [63:0] vis_t, flk_t;
  logic [43:0] hy, hc;
  logic [39:0] ly, lc;
  always_comb begin
    hy = 44'(fy_sq[51:24]) * 44'(luma_weight);
    hc = 44'(fc_sq[51:24]) * 44'(chroma_weight);
    ly = 40'(fy_sq[23:0]) * 40'(luma_weight) + 40'(1 << 23);
    lc = 40'(fc_sq[23:0]) * 40'(chroma_weight) + 40'(1 << 23);
  end
  always_ff @(posedge clk) begin
    vis_t <= 64'((55'(vis_sq) + 55'(1 << 17)) >> 18);
    flk_t <= 64'(hy) + 64'(ly[39:24]) + 64'(hc) + 64'(lc[39:24]);
  end

  // stage 5: accumulate; the result folds in the last pixel's terms directly
  logic [63:0] vsum, fsum, vfin, ffin;
  always_comb begin
    vfin = sat_add(vsum, vis_t);
    ffin = sat_add(fsum, flk_t);
  end
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      vsum <= '0;
      fsum <= '0;
    end else if (stage_valid[3]) begin
      vsum <= vfin;
      fsum <= ffin;
    end
    if (cmd.issue) begin
      visual_error <= vfin;
      flicker_error <= ffin;
      total_error <= sat_add(vfin, ffin);
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/dffea_ctrl.sv
// Controller: pixel pipeline tracking, result issue and output handshake.
`default_nettype none
module dffea_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic in_action,
  input  wire logic in_last,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output dffea_pkg::dffea_cmd_t cmd,
  output logic [3:0] stage_valid
);
  import dffea_pkg::*;
  typedef enum logic [1:0] {S_RUN = 2'b01, S_HOLD = 2'b10} state_t;
  state_t state, state_next;
  logic [3:0] lastv;
  logic done;

  // the last pixel reaches the sums after stage 4; issue then
  assign done = stage_valid[3] && lastv[3];
  // a last pixel in flight or a held result blocks all input
  assign in_ready = !(lastv != 4'd0 || (state == S_HOLD && !out_ready));
  assign cmd.load = in_fire && in_action == ACT_LOAD;
  assign cmd.issue = done;
  assign cmd.clear = 1'b0;

  always_comb begin
    state_next = state;
    case (state)
      S_RUN: if (done) state_next = S_HOLD;
      S_HOLD: if (out_ready) state_next = done ? S_HOLD : S_RUN;
      default: state_next = S_RUN;
    endcase
  end
  assign out_valid = state == S_HOLD;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      stage_valid <= '0;
      lastv <= '0;
    end else begin
      state <= state_next;
      stage_valid <= {stage_valid[2:0], in_fire && in_action == ACT_PIXEL};
      lastv <= {lastv[2:0], in_fire && in_action == ACT_PIXEL && in_last};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/dual_frame_flicker_error_accumulator_unit.sv
// Top level of the dual-frame flicker error scorer.
//  channel | dir | payload
//  in      | in  | action, entry_index, red, green, blue, index_a, index_b, last_pixel
//  out     | out | visual_error, flicker_error, total_error
//  cfg     | in  | cfg_we, cfg_index, cfg_data (luma_weight, chroma_weight)
// One item a cycle through a five-stage pipeline (palette read, convert, square,
// weigh, accumulate) while in_ready is high. A last pixel's result is registered
// once its terms reach the sums; input pauses while the pipeline drains into the sums.
// Synchronous reset clears control state and sets both weights to 256.
// A stalled result holds the output register and blocks all input until taken.
`default_nettype none
module dual_frame_flicker_error_accumulator_unit #(
  parameter int PALETTE_ENTRIES = dffea_pkg::PALETTE_ENTRIES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  dffea_in_if.sink in_ch,
  dffea_out_if.source out_ch,
  input wire logic cfg_we,
  input wire logic [dffea_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [dffea_pkg::CFG_W-1:0] cfg_data
);
  import dffea_pkg::*;
  logic [15:0] luma_weight, chroma_weight;
  dffea_cmd_t cmd, cmd_dp;
  logic [3:0] stage_valid;
  logic in_fire, issue_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_weight <= 16'd256;
      chroma_weight <= 16'd256;
      issue_d <= 1'b0;
    end else begin
      issue_d <= cmd.issue;
      if (cfg_we) begin
        case (cfg_index)
          REG_LUMA_WEIGHT: luma_weight <= cfg_data;
          REG_CHROMA_WEIGHT: chroma_weight <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign in_fire = in_ch.valid && in_ch.ready;
  // sums clear on issue; reset clears them via the clear as well
  always_comb begin
    cmd_dp = cmd;
    cmd_dp.clear = cmd.issue || rst;
  end

  dffea_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_action(in_ch.action),
    .in_last(in_ch.last_pixel), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .cmd(cmd), .stage_valid(stage_valid)
  );

  dffea_datapath #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_dp (
    .clk(clk), .cmd(cmd_dp), .entry_index(in_ch.entry_index),
    .color({in_ch.red, in_ch.green, in_ch.blue}), .index_a(in_ch.index_a),
    .index_b(in_ch.index_b), .luma_weight(luma_weight), .chroma_weight(chroma_weight),
    .stage_valid(stage_valid & {~issue_d, 3'b111}), .visual_error(out_ch.visual_error),
    .flicker_error(out_ch.flicker_error), .total_error(out_ch.total_error)
  );
endmodule
`default_nettype wire

>>> rtl/core/dffea_checker.sv
// Port-level checks for the flicker error scorer, bound to the top level.
`default_nettype none
module dffea_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [63:0] visual_error,
  input wire logic [63:0] flicker_error,
  input wire logic [63:0] total_error
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_error)) else $error("result dropped");
  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> total_error >= visual_error && total_error >= flicker_error)
    else $error("total below part");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_valid && in_ready |=> out_valid) else $error("stall lost");
endmodule

bind dual_frame_flicker_error_accumulator_unit dffea_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .visual_error(out_ch.visual_error), .flicker_error(out_ch.flicker_error),
  .total_error(out_ch.total_error)
);
`default_nettype wire
